// File: hdl/ntb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntb_pkg: shared definitions of the nucleotide 2-bit encoder
// Character codes, generator constants and the result beat type.
// ----------------------------------------------------------------------------
package ntb_pkg;

  localparam int unsigned IndexWidthDefault = 32;

  // Minimal-standard generator: x = x * 48271 mod (2^31 - 1)
  localparam logic [31:0] LcgMod = 32'h7FFF_FFFF;
  localparam logic [15:0] LcgMul = 16'd48271;

  // Upper-case nucleotide letters
  localparam logic [7:0] CharA = 8'h41;
  localparam logic [7:0] CharC = 8'h43;
  localparam logic [7:0] CharG = 8'h47;
  localparam logic [7:0] CharT = 8'h54;

  localparam logic [1:0] CodeA = 2'd0;
  localparam logic [1:0] CodeC = 2'd1;
  localparam logic [1:0] CodeG = 2'd2;
  localparam logic [1:0] CodeT = 2'd3;

  // One result beat, position travels beside it
  typedef struct packed {
    logic [1:0]  code;
    logic        ambiguous;
    logic        run_start;
    logic [31:0] run_length;
    logic [7:0]  run_symbol;
    logic        pad;
    logic        last_result;
  } ntb_beat_t;

  typedef struct packed {
    logic      valid;
    ntb_beat_t beat;
  } ntb_push_t;

endpackage

// File: hdl/ntb_lcg_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntb_lcg_step: one step of the minimal-standard generator
// Constant multiply, Mersenne fold and one corrective subtract.
// ----------------------------------------------------------------------------
module ntb_lcg_step
  import ntb_pkg::*;
(
  input  logic [30:0] x_i,
  output logic [30:0] next_o
);

  logic [46:0] prod;
  logic [31:0] fold;
  logic [31:0] fixed;

  // prod = hi * 2^31 + lo, and 2^31 == 1 mod M, so hi + lo stays below 2M
  assign prod  = {16'd0, x_i} * {31'd0, LcgMul};
  assign fold  = {1'b0, prod[30:0]} + {16'd0, prod[46:31]};
  assign fixed = (fold >= LcgMod) ? (fold - LcgMod) : fold;
  assign next_o = fixed[30:0];

endmodule

// File: hdl/ntb_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntb_core: classification, run tracking and pad sequencing
// Holds the sequence state and issues one result beat per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module ntb_core
  import ntb_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = IndexWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             symbol_i,
  input  logic                   is_first_i,
  input  logic                   is_final_i,
  input  logic                   can_push_i,
  output ntb_push_t              push_o,
  output logic [INDEX_WIDTH-1:0] position_o
);

  logic [30:0]            seed_q, seed_d;
  logic [30:0]            lcg_q;
  logic [7:0]             prev_q;
  logic [INDEX_WIDTH-1:0] idx_q;
  logic [31:0]            run_q;
  logic [1:0]             pad_cnt_q;

  logic [31:0]            seed_sum, seed_mod;
  logic [30:0]            lcg_eff, lcg_in, lcg_next;
  logic [7:0]             prev_eff;
  logic [INDEX_WIDTH-1:0] idx_eff, idx_new;
  logic [31:0]            run_eff, run_new;
  logic [1:0]             base_code, pads;
  logic                   amb, start, pad_busy, accept, pad_fire;

  // Reduce the seed at write time: fold bit 31, subtract once, map zero to one
  assign seed_sum = {1'b0, cfg_wdata_i[30:0]} + {31'd0, cfg_wdata_i[31]};
  assign seed_mod = (seed_sum >= LcgMod) ? (seed_sum - LcgMod) : seed_sum;
  assign seed_d   = (seed_mod == 32'd0) ? 31'd1 : seed_mod[30:0];

  assign pad_busy   = (pad_cnt_q != 2'd0);
  assign in_ready_o = can_push_i && !pad_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign pad_fire   = pad_busy && can_push_i;

  // A first item starts from a fresh state
  assign lcg_eff  = is_first_i ? seed_q : lcg_q;
  assign prev_eff = is_first_i ? 8'd0 : prev_q;
  assign idx_eff  = is_first_i ? '0 : idx_q;
  assign run_eff  = is_first_i ? 32'd0 : run_q;

  assign lcg_in = pad_busy ? lcg_q : lcg_eff;

  ntb_lcg_step u_lcg (
    .x_i   (lcg_in),
    .next_o(lcg_next)
  );

  assign amb = !(symbol_i inside {CharA, CharC, CharG, CharT});

  always_comb begin
    case (symbol_i)
      CharA:   base_code = CodeA;
      CharC:   base_code = CodeC;
      CharG:   base_code = CodeG;
      CharT:   base_code = CodeT;
      default: base_code = CodeA;
    endcase
  end

  assign start   = (symbol_i != prev_eff);
  assign run_new = !amb ? 32'd0 : (start ? 32'd1 : run_eff + 32'd1);
  assign idx_new = idx_eff + {{(INDEX_WIDTH-1){1'b0}}, 1'b1};
  assign pads    = 2'd0 - idx_new[1:0];

  always_comb begin
    push_o.valid = accept || pad_fire;
    if (pad_busy) begin
      push_o.beat.code        = lcg_next[1:0];
      push_o.beat.ambiguous   = 1'b0;
      push_o.beat.run_start   = 1'b0;
      push_o.beat.run_length  = 32'd0;
      push_o.beat.run_symbol  = 8'd0;
      push_o.beat.pad         = 1'b1;
      push_o.beat.last_result = (pad_cnt_q == 2'd1);
      position_o              = idx_q;
    end else begin
      push_o.beat.code        = amb ? lcg_next[1:0] : base_code;
      push_o.beat.ambiguous   = amb;
      push_o.beat.run_start   = amb && start;
      push_o.beat.run_length  = run_new;
      push_o.beat.run_symbol  = amb ? symbol_i : 8'd0;
      push_o.beat.pad         = 1'b0;
      push_o.beat.last_result = is_final_i && (pads == 2'd0);
      position_o              = idx_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= 31'd1;
      lcg_q     <= 31'd1;
      prev_q    <= 8'd0;
      idx_q     <= '0;
      run_q     <= 32'd0;
      pad_cnt_q <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= seed_d;
      end
      if (accept) begin
        lcg_q     <= amb ? lcg_next : lcg_eff;
        prev_q    <= symbol_i;
        idx_q     <= idx_new;
        run_q     <= run_new;
        pad_cnt_q <= is_final_i ? pads : 2'd0;
      end else if (pad_fire) begin
        lcg_q     <= lcg_next;
        idx_q     <= idx_q + {{(INDEX_WIDTH-1){1'b0}}, 1'b1};
        pad_cnt_q <= pad_cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: hdl/ntb_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntb_out_queue: two-entry result queue
// Head register drives the output; a second entry absorbs one stalled beat.
// ----------------------------------------------------------------------------
module ntb_out_queue
  import ntb_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = IndexWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ntb_push_t              push_i,
  input  logic [INDEX_WIDTH-1:0] position_i,
  output logic                   can_push_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ntb_beat_t              beat_o,
  output logic [INDEX_WIDTH-1:0] position_o
);

  localparam logic [1:0] CntEmpty = 2'd0;
  localparam logic [1:0] CntOne   = 2'd1;
  localparam logic [1:0] CntFull  = 2'd2;

  logic [1:0]             cnt_q, cnt_d;
  ntb_beat_t              head_q, tail_q;
  logic [INDEX_WIDTH-1:0] head_pos_q, tail_pos_q;
  logic                   push, pop;

  assign can_push_o  = (cnt_q != CntFull);
  assign out_valid_o = (cnt_q != CntEmpty);
  assign push        = push_i.valid && can_push_o;
  assign pop         = out_valid_o && out_ready_i;
  assign beat_o      = head_q;
  assign position_o  = head_pos_q;

  always_comb begin
    cnt_d = cnt_q;
    case (cnt_q)
      CntEmpty: if (push) cnt_d = CntOne;
      CntOne:   if (push && !pop) cnt_d = CntFull;
                else if (!push && pop) cnt_d = CntEmpty;
      CntFull:  if (pop) cnt_d = CntOne;
      default:  cnt_d = CntEmpty;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntEmpty;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload: a pop from full moves tail to head; a push loads head when it is free or leaving, else parks in tail
  always_ff @(posedge clk_i) begin
    if (cnt_q == CntFull) begin
      if (pop) begin
        head_q     <= tail_q;
        head_pos_q <= tail_pos_q;
      end
    end else if (push) begin
      if (cnt_q == CntEmpty || pop) begin
        head_q     <= push_i.beat;
        head_pos_q <= position_i;
      end else begin
        tail_q     <= push_i.beat;
        tail_pos_q <= position_i;
      end
    end
  end

endmodule

// File: hdl/nucleotide_text_to_2bit_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nucleotide_text_to_2bit_encoder_top: text to 2-bit nucleotide codes
// Encodes one ASCII character per beat, tracks ambiguity runs, pads output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one character per beat
//   with is_first_i to start a sequence and is_final_i to close it.
//   Output channel (out_valid_o / out_ready_i) carries one code per beat.
//   A, C, G, T map to 0..3; any other byte draws two random bits from the
//   minimal-standard generator and is flagged as part of a hole run.
//   A result is registered in the result queue before it shows on the output.
//   Throughput: one character per cycle while the result queue has room; the generator
//   step (constant multiply and Mersenne fold) is combinational. A final character adds
//   0 to 3 pad beats, one per cycle while the queue has room, and input is held off meanwhile.
//   cfg_we_i writes the seed; write it only while the block is idle. It is
//   loaded into the generator by the next is_first_i beat.
//   Reset: seed and generator go to one, index, run length and previous
//   character clear, the result queue empties.
//   Stall: a two-entry result queue holds waiting beats; input is still
//   taken until both entries are full.
// ----------------------------------------------------------------------------
module nucleotide_text_to_2bit_encoder_top
  import ntb_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = IndexWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             symbol_i,
  input  logic                   is_first_i,
  input  logic                   is_final_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             code_o,
  output logic [INDEX_WIDTH-1:0] position_o,
  output logic                   ambiguous_o,
  output logic                   run_start_o,
  output logic [31:0]            run_length_o,
  output logic [7:0]             run_symbol_o,
  output logic                   pad_o,
  output logic                   last_result_o
);

  ntb_push_t              push;
  logic [INDEX_WIDTH-1:0] push_pos;
  logic                   can_push;
  ntb_beat_t              beat;

  // Encode each accepted beat, and issue pad beats after a final one
  ntb_core #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .symbol_i   (symbol_i),
    .is_first_i (is_first_i),
    .is_final_i (is_final_i),
    .can_push_i (can_push),
    .push_o     (push),
    .position_o (push_pos)
  );

  // Hold results until the receiver takes them
  ntb_out_queue #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .position_i (push_pos),
    .can_push_o (can_push),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .beat_o     (beat),
    .position_o (position_o)
  );

  assign code_o        = beat.code;
  assign ambiguous_o   = beat.ambiguous;
  assign run_start_o   = beat.run_start;
  assign run_length_o  = beat.run_length;
  assign run_symbol_o  = beat.run_symbol;
  assign pad_o         = beat.pad;
  assign last_result_o = beat.last_result;

endmodule

// File: hdl/ntb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntb_checker: port-level checks of the nucleotide 2-bit encoder
// Watches the handshakes and result fields over time; bound to the top level.
// ----------------------------------------------------------------------------
module ntb_checker
  import ntb_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = IndexWidthDefault
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [1:0]             code_o,
  input logic [INDEX_WIDTH-1:0] position_o,
  input logic                   ambiguous_o,
  input logic                   run_start_o,
  input logic [31:0]            run_length_o,
  input logic                   pad_o,
  input logic                   last_result_o
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_o) &&
      $stable(position_o) && $stable(pad_o) && $stable(last_result_o))
    else $error("result beat changed while stalled");

  // After an accepted character the output is valid in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // Pad beats carry no run information
  a_pad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pad_o |-> !ambiguous_o && !run_start_o && run_length_o == 32'd0)
    else $error("pad beat carries run fields");

  // A pad that is not the last is followed at once by the next pad
  a_pad_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && pad_o && !last_result_o |=> out_valid_o && pad_o)
    else $error("pad sequence broken");

endmodule

bind nucleotide_text_to_2bit_encoder_top ntb_checker #(
  .INDEX_WIDTH(INDEX_WIDTH)
) u_ntb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .code_o       (code_o),
  .position_o   (position_o),
  .ambiguous_o  (ambiguous_o),
  .run_start_o  (run_start_o),
  .run_length_o (run_length_o),
  .pad_o        (pad_o),
  .last_result_o(last_result_o)
);
